// ----- rtl/pfl_pkg.sv -----
package pfl_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int LINK_W    = PAGE_W + 1;
    localparam int NUM_W     = 12;
    localparam int OP_W      = 3;
    localparam int ST_W      = 3;

    localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(MAX_PAGES);
    localparam logic [LINK_W-1:0] LINK_USED = LINK_W'(MAX_PAGES + 1);
    localparam logic [LINK_W-1:0] COUNT_MAX = LINK_W'(MAX_PAGES);

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_DISPOSE = 3'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT    = 3'd3;
    localparam logic [OP_W-1:0] OP_PREV    = 3'd4;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_INVALID = 3'd2,
        ST_FREE    = 3'd3,
        ST_NONE    = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [PAGE_W-1:0] page;
    } res_t;

endpackage

// ----- rtl/pfl_ram.sv -----
module pfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/pfl_seq.sv -----
module pfl_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         store_open,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pfl_pkg::OP_W-1:0]     op,
    input  logic [pfl_pkg::NUM_W-1:0]    page_number,
    output pfl_pkg::res_t                res,
    input  logic                         res_take
);
    import pfl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_LOOK  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [NUM_W-1:0]   page_reg, page_next;
    logic [NUM_W-1:0]   cursor_reg, cursor_next;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [LINK_W-1:0]  count_reg, count_next;
    status_t            status_reg, status_next;
    logic [PAGE_W-1:0]  pout_reg, pout_next;

    logic               ram_we;
    logic [PAGE_W-1:0]  ram_waddr;
    logic [LINK_W-1:0]  ram_wdata;
    logic [PAGE_W-1:0]  ram_raddr;
    logic [LINK_W-1:0]  ram_rdata;

    logic               p_valid;
    logic               p_is_count;
    logic               p_is_m1;
    logic               cur_out;
    logic               head_avail;
    logic               rd_used;
    logic [NUM_W-1:0]   step_base;
    logic [NUM_W-1:0]   step;

    pfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_PAGES)
    ) u_link (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign p_valid    = !page_reg[NUM_W-1] && (LINK_W'(page_reg[NUM_W-2:0]) < count_reg);
    assign p_is_count = !page_reg[NUM_W-1] && (LINK_W'(page_reg[NUM_W-2:0]) == count_reg);
    assign p_is_m1    = (page_reg == {NUM_W{1'b1}});
    assign cur_out    = cursor_reg[NUM_W-1] || (LINK_W'(cursor_reg[NUM_W-2:0]) >= count_reg);
    assign head_avail = (head_reg < count_reg);
    assign rd_used    = (ram_rdata == LINK_USED);

    // the one cursor adder: first step from the start page, then from the cursor
    assign step_base = (state_reg == S_START) ? page_reg : cursor_reg;
    assign step      = (op_reg == OP_PREV) ? (step_base - NUM_W'(1)) : (step_base + NUM_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        page_next   = page_reg;
        cursor_next = cursor_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pout_next   = pout_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    page_next  = page_number;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next  = S_RESP;
                status_next = ST_INVALID;
                pout_next   = '0;
                cursor_next = step;
                if (!store_open)
                begin
                    status_next = ST_CLOSED;
                end
                else
                begin
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            if (head_avail)
                            begin
                                ram_raddr  = head_reg[PAGE_W-1:0];
                                state_next = S_EVAL;
                            end
                            else if (count_reg == COUNT_MAX)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // free list empty: grow the store by one page
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[PAGE_W-1:0];
                                ram_wdata   = LINK_USED;
                                count_next  = count_reg + LINK_W'(1);
                                status_next = ST_OK;
                                pout_next   = count_reg[PAGE_W-1:0];
                            end
                        end
                        OP_DISPOSE, OP_CHECK:
                        begin
                            if (p_valid)
                            begin
                                ram_raddr  = page_reg[PAGE_W-1:0];
                                state_next = S_EVAL;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (p_valid || p_is_m1)
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        OP_PREV:
                        begin
                            if (p_valid || p_is_count)
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (cur_out)
                begin
                    status_next = ST_NONE;
                    pout_next   = '0;
                    state_next  = S_RESP;
                end
                else
                begin
                    ram_raddr  = cursor_reg[PAGE_W-1:0];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next  = S_RESP;
                status_next = ST_OK;
                pout_next   = '0;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        head_next = ram_rdata;
                        ram_we    = 1'b1;
                        ram_waddr = head_reg[PAGE_W-1:0];
                        ram_wdata = LINK_USED;
                        pout_next = head_reg[PAGE_W-1:0];
                    end
                    OP_DISPOSE:
                    begin
                        if (!rd_used)
                        begin
                            status_next = ST_FREE;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = page_reg[PAGE_W-1:0];
                            ram_wdata = head_reg;
                            head_next = LINK_W'(page_reg[PAGE_W-1:0]);
                        end
                    end
                    OP_CHECK:
                    begin
                        if (rd_used)
                        begin
                            pout_next = page_reg[PAGE_W-1:0];
                        end
                        else
                        begin
                            status_next = ST_INVALID;
                        end
                    end
                    default:
                    begin
                        // scans: stop on a used page, else move the cursor on
                        if (rd_used)
                        begin
                            pout_next = cursor_reg[PAGE_W-1:0];
                        end
                        else
                        begin
                            cursor_next = step;
                            state_next  = S_LOOK;
                        end
                    end
                endcase
            end
            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= LINK_END;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        page_reg   <= page_next;
        cursor_reg <= cursor_next;
        status_reg <= status_next;
        pout_reg   <= pout_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_RESP);
    assign res.status = status_reg;
    assign res.page   = pout_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("page count beyond maximum");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == LINK_END) || (head_reg < count_reg))
        else $error("free list head out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((count_reg == $past(count_reg))
                  || (count_reg == $past(count_reg) + LINK_W'(1))))
        else $error("page count moved by more than one");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == S_START) || (state_reg == S_EVAL)))
        else $error("link store written outside start or eval");

endmodule

// ----- rtl/page_free_list_allocator.sv -----
// Page allocator over a linked free list of 1024 pages held in a simple dual-port
// link RAM (one write and one registered read a cycle). One item is worked at
// a time; in_ready is high only while the sequencer is idle, and a finished
// result sits in the output register while the next item is taken. Allocate,
// dispose and check go from the start state through an optional link RAM read
// in the eval state to the result; a next or previous scan moves its cursor on
// from the start page until it stops on a used page or runs off the end, and
// each visited page costs one link RAM read and one compare. No clearing
// pass after reset: only pages below the page count are ever read. store_open
// (address 0, bit 0) must be set before any operation is served; writes are
// expected only while the block is idle.
module page_free_list_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pfl_pkg::OP_W-1:0]     op,
    input  logic signed [pfl_pkg::NUM_W-1:0] page_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pfl_pkg::ST_W-1:0]     status,
    output logic [pfl_pkg::PAGE_W-1:0]   page_out
);
    import pfl_pkg::*;

    logic               open_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [PAGE_W-1:0]  page_out_reg;
    res_t               res;
    logic               res_take;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {31'd0, open_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            open_reg <= pwdata[0];
        end
    end

    pfl_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .store_open  (open_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .page_number (page_number),
        .res         (res),
        .res_take    (res_take)
    );

    // output slot frees up in the same cycle it is drained
    assign res_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res.valid)
        begin
            status_reg   <= res.status;
            page_out_reg <= res.page;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign page_out  = page_out_reg;

endmodule

// ----- dv/tb_page_free_list_allocator.sv -----
module tb_page_free_list_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import pfl_pkg::*;

    localparam logic [2:0]      ADDR_STORE_OPEN = 3'd0;
    localparam logic [OP_W-1:0] OP_UNUSED_LO    = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI    = 3'd7;
    localparam int              CLOSED_ROWS     = 3;
    localparam int              SCRIPT_LEN      = 28;
    localparam int              IDLE_PCT        = 16;
    localparam longint          RUN_LIMIT_NS    = 64'd4_000_000;

    typedef struct {
        status_t           st;
        logic [PAGE_W-1:0] pg;
    } answer_t;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [NUM_W-1:0] pn;
        bit                      typed;
        status_t                 st;
        logic [PAGE_W-1:0]       pg;
    } script_row_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     psel        = 1'b0;
    logic                     penable     = 1'b0;
    logic                     pwrite      = 1'b0;
    logic [2:0]               paddr       = '0;
    logic [31:0]              pwdata      = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          op          = '0;
    logic signed [NUM_W-1:0]  page_number = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [ST_W-1:0]          status;
    logic [PAGE_W-1:0]        page_out;

    // shadow of the allocator state
    logic [LINK_W-1:0] link_words [MAX_PAGES];
    logic [LINK_W-1:0] free_head  = LINK_END;
    logic [LINK_W-1:0] page_count = '0;
    logic              store_open = 1'b0;

    answer_t answers_due [$];
    answer_t due_now;
    int      mismatches = 0;
    int      idle_pct   = IDLE_PCT;

    // closed rows first, the rest run with the store open
    script_row_t script_rows [SCRIPT_LEN] = '{
        '{OP_ALLOC,      0,     1'b1, ST_CLOSED,  0},
        '{OP_DISPOSE,    0,     1'b1, ST_CLOSED,  0},
        '{OP_UNUSED_HI,  -1,    1'b1, ST_CLOSED,  0},
        '{OP_CHECK,      0,     1'b1, ST_INVALID, 0},
        '{OP_NEXT,       -1,    1'b1, ST_NONE,    0},
        '{OP_PREV,       0,     1'b1, ST_NONE,    0},
        '{OP_DISPOSE,    -1,    1'b1, ST_INVALID, 0},
        '{OP_ALLOC,      0,     1'b1, ST_OK,      0},
        '{OP_ALLOC,      2047,  1'b1, ST_OK,      1},
        '{OP_ALLOC,      -2048, 1'b1, ST_OK,      2},
        '{OP_CHECK,      1,     1'b1, ST_OK,      1},
        '{OP_DISPOSE,    1,     1'b1, ST_OK,      0},
        '{OP_DISPOSE,    1,     1'b1, ST_FREE,    0},
        '{OP_CHECK,      1,     1'b1, ST_INVALID, 0},
        '{OP_NEXT,       -1,    1'b1, ST_OK,      0},
        '{OP_NEXT,       0,     1'b0, ST_OK,      0},
        '{OP_PREV,       3,     1'b0, ST_OK,      0},
        '{OP_PREV,       2,     1'b0, ST_OK,      0},
        '{OP_NEXT,       2,     1'b0, ST_OK,      0},
        '{OP_NEXT,       3,     1'b0, ST_OK,      0},
        '{OP_PREV,       -1,    1'b0, ST_OK,      0},
        '{OP_ALLOC,      0,     1'b0, ST_OK,      0},
        '{OP_UNUSED_LO,  0,     1'b1, ST_INVALID, 0},
        '{OP_UNUSED_MID, 2047,  1'b1, ST_INVALID, 0},
        '{OP_UNUSED_HI,  -2048, 1'b1, ST_INVALID, 0},
        '{OP_CHECK,      2047,  1'b1, ST_INVALID, 0},
        '{OP_DISPOSE,    -2048, 1'b1, ST_INVALID, 0},
        '{OP_PREV,       1024,  1'b0, ST_OK,      0}
    };

    page_free_list_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .page_number (page_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .page_out    (page_out)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= idle_pct);

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic page_op_answer(input logic [OP_W-1:0] o,
                                  input logic signed [NUM_W-1:0] pn,
                                  output answer_t a);
        int p;
        int cnt;
        int pg;
        bit valid;
        p     = pn;
        cnt   = page_count;
        valid = (p >= 0) && (p < cnt);
        a.st  = ST_OK;
        a.pg  = '0;
        if (!store_open)
        begin
            a.st = ST_CLOSED;
            return;
        end
        case (o)
            OP_ALLOC:
            begin
                if (free_head < page_count && free_head < MAX_PAGES)
                begin
                    pg        = free_head;
                    free_head = link_words[pg];
                end
                else if (cnt >= MAX_PAGES)
                begin
                    a.st = ST_FULL;
                    return;
                end
                else
                begin
                    pg         = cnt;
                    page_count = page_count + 1'b1;
                end
                link_words[pg] = LINK_USED;
                a.pg = PAGE_W'(pg);
            end
            OP_DISPOSE:
            begin
                if (!valid)
                    a.st = ST_INVALID;
                else if (link_words[p] != LINK_USED)
                    a.st = ST_FREE;
                else
                begin
                    link_words[p] = free_head;
                    free_head     = LINK_W'(p);
                end
            end
            OP_CHECK:
            begin
                if (valid && link_words[p] == LINK_USED)
                    a.pg = PAGE_W'(p);
                else
                    a.st = ST_INVALID;
            end
            OP_NEXT:
            begin
                if (p != -1 && !valid)
                    a.st = ST_INVALID;
                else
                begin
                    a.st = ST_NONE;
                    for (int c = p + 1; c < cnt; c++)
                        if (link_words[c] == LINK_USED)
                        begin
                            a.st = ST_OK;
                            a.pg = PAGE_W'(c);
                            break;
                        end
                end
            end
            OP_PREV:
            begin
                // a backward scan may also start one past the last page
                if (p != cnt && !valid)
                    a.st = ST_INVALID;
                else
                begin
                    a.st = ST_NONE;
                    for (int c = p - 1; c >= 0; c--)
                        if (link_words[c] == LINK_USED)
                        begin
                            a.st = ST_OK;
                            a.pg = PAGE_W'(c);
                            break;
                        end
                end
            end
            default:
                a.st = ST_INVALID;
        endcase
    endtask

    // valid is left high after acceptance so back-to-back items need no toggle
    task automatic send_item(input logic [OP_W-1:0] o,
                             input logic signed [NUM_W-1:0] pn,
                             input bit typed = 1'b0,
                             input status_t t_st = ST_OK,
                             input logic [PAGE_W-1:0] t_pg = '0);
        int gap;
        answer_t a;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        page_number <= pn;
        do
            @(posedge clk);
        while (!in_ready);
        page_op_answer(o, pn, a);
        if (typed)
        begin
            a.st = t_st;
            a.pg = t_pg;
        end
        answers_due.push_back(a);
    endtask

    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_block();
        drain_answers();
        repeat (8) @(posedge clk);
    endtask

    task automatic set_store_open(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STORE_OPEN;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        store_open = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        // read back in the same two-phase form
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {31'b0, store_open})
            report_mismatch($sformatf("store_open reads %h, written %h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [NUM_W-1:0] pick_page(input bit want_used);
        int r;
        int pg;
        r = $urandom_range(99);
        if (r < 72 && page_count != 0)
        begin
            pg = $urandom_range(int'(page_count) - 1);
            for (int t = 0; t < 6 && want_used && link_words[pg] != LINK_USED; t++)
                pg = $urandom_range(int'(page_count) - 1);
            return NUM_W'(pg);
        end
        if (r < 82)
            return NUM_W'(page_count);
        if (r < 90)
            return '1;
        return NUM_W'($urandom);
    endfunction

    task automatic send_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 32)
            send_item(OP_ALLOC, NUM_W'($urandom));
        else if (r < 56)
            send_item(OP_DISPOSE, pick_page(1'b1));
        else if (r < 70)
            send_item(OP_CHECK, pick_page(1'b1));
        else if (r < 82)
            send_item(OP_NEXT, pick_page(1'b0));
        else if (r < 94)
            send_item(OP_PREV, pick_page(1'b0));
        else if (r < 97)
            send_item(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), NUM_W'($urandom));
        else
            send_item(OP_W'($urandom_range(7)), NUM_W'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
                report_mismatch($sformatf("item out with nothing due: status %0d page %0d",
                                          status, page_out));
            else
            begin
                due_now = answers_due.pop_front();
                if (status !== due_now.st)
                    report_mismatch($sformatf("status %0d, due %s", status, due_now.st.name()));
                if (page_out !== due_now.pg)
                    report_mismatch($sformatf("page_out %0d, due %0d", page_out, due_now.pg));
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i])
        begin
            if (i == CLOSED_ROWS)
            begin
                settle_block();
                set_store_open(32'h1);
            end
            send_item(script_rows[i].op, script_rows[i].pn, script_rows[i].typed,
                      script_rows[i].st, script_rows[i].pg);
        end

        for (int i = 0; i < 230; i++)
        begin
            // hold the sender until the block has answered everything
            if (i == 115)
                drain_answers();
            send_random_item();
        end

        settle_block();
        set_store_open($urandom & 32'hFFFF_FFFE);
        for (int i = 0; i < 20; i++)
            send_random_item();

        settle_block();
        set_store_open($urandom | 32'h1);
        for (int i = 0; i < 280; i++)
        begin
            if (i == 40)
                idle_pct = 0;
            if (i == 200)
                idle_pct = IDLE_PCT;
            send_random_item();
        end

        // poke at the top and bottom page numbers
        repeat (3) send_item(OP_ALLOC, NUM_W'($urandom));
        send_item(OP_CHECK, 1023);
        send_item(OP_DISPOSE, 1023);
        send_item(OP_DISPOSE, 0);
        send_item(OP_CHECK, 1024);
        send_item(OP_NEXT, -1);
        send_item(OP_PREV, 1024);
        send_item(OP_ALLOC, 0);
        send_item(OP_ALLOC, 0);
        send_item(OP_ALLOC, 0);
        send_item(OP_NEXT, 1022);
        send_item(OP_NEXT, 1023);
        send_item(OP_PREV, 0);
        for (int i = 0; i < 12; i++)
            send_random_item();

        drain_answers();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pfl_pkg.sv
rtl/pfl_ram.sv
rtl/pfl_seq.sv
rtl/page_free_list_allocator.sv
dv/tb_page_free_list_allocator.sv
